@@ design/bsrm_pkg.sv @@
`default_nettype none
package bsrm_pkg;

   localparam int WORD_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int CHAR_W   = 7;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 7'd10;

   // command codes carried in req_tuser; codes 6 and 7 fall to the default arm
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH  = 3'd0,
      MODE_MOD   = 3'd1,
      MODE_PCHAR = 3'd2,
      MODE_PSTR  = 3'd3,
      MODE_ROTL  = 3'd4,
      MODE_ROTR  = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_SHORT  = 3'd1,
      ST_DIVZ   = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_NASCII = 3'd4,
      ST_FULL   = 3'd5
   } status_type;

   // per-cell move: UP takes the neighbor nearer the top, DOWN the one nearer the bottom
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_UP   = 2'd1,
      CELL_DOWN = 2'd2,
      CELL_LOAD = 2'd3
   } cell_op_type;

   // whole-chain move chosen by the sequencer
   typedef enum logic [1:0] {
      CHAIN_HOLD = 2'd0,
      CHAIN_PUSH = 2'd1,
      CHAIN_POP  = 2'd2,
      CHAIN_ROT  = 2'd3
   } chain_op_type;

   typedef struct packed {
      status_type         status;
      logic               has_char;
      logic [CHAR_W-1:0]  char_out;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

@@ design/bsrm_cell.sv @@
`default_nettype none
// One stack slot. Chain order: slot 0 holds the top word.
module bsrm_cell (
   input  wire                            clock,
   input  wire bsrm_pkg::cell_op_type     op,
   input  wire [bsrm_pkg::WORD_W-1:0]     from_up,
   input  wire [bsrm_pkg::WORD_W-1:0]     from_down,
   input  wire [bsrm_pkg::WORD_W-1:0]     load_word,
   output logic [bsrm_pkg::WORD_W-1:0]    word
);
   import bsrm_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      case (op)
         CELL_HOLD: word_in = word_ff;
         CELL_UP:   word_in = from_up;
         CELL_DOWN: word_in = from_down;
         CELL_LOAD: word_in = load_word;
         default:   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule
`default_nettype wire

@@ design/bsrm_divider.sv @@
`default_nettype none
// Restoring remainder, one bit per cycle on magnitudes; sign follows the dividend.
module bsrm_divider (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire [bsrm_pkg::WORD_W-1:0]     dividend,
   input  wire [bsrm_pkg::WORD_W-1:0]     divisor,
   output logic                           done,
   output logic [bsrm_pkg::WORD_W-1:0]    remainder
);
   import bsrm_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] mag_ff, mag_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, mag_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[WORD_W-1];
         quo_in  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
         mag_in  = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         rem_in = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = neg_ff ? (WORD_W'(0) - rem_ff) : rem_ff;

endmodule
`default_nettype wire

@@ design/bounded_stack_rotate_mod_engine.sv @@
// Bounded stack of signed 32-bit words driven by one command per request transaction
// (req_tuser = command, req_tdata = word to push). Every command answers with one or more
// response transactions; rsp_tlast marks the final one. Push, rotate-left, pchar and error
// cases load their first response from S_EXEC, the state after the accept, once the output
// register is free. Mod hands the top two words to the bit-serial remainder unit (one
// quotient bit per cycle) and answers from S_DONE once the remainder is back in slot 0.
// Rotate-right circulates the live words through the cell chain one slot per cycle and
// answers from S_DONE; pstr walks every live word past slot 0 while printing, then puts
// out its newline. Back-pressure on rsp_tready holds each response and the pstr walk.
// The chain walk and the divider set the command rate. One command is in flight at a time;
// a new request can be accepted the cycle after the last response of the previous one has
// been loaded into the output register.
`default_nettype none
module bounded_stack_rotate_mod_engine #(
   parameter int STACK_DEPTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [bsrm_pkg::REQ_TDATA_W-1:0]      req_tdata,   // [31:0] value
   input  wire [bsrm_pkg::MODE_W-1:0]           req_tuser,   // [2:0] mode
   // response
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [bsrm_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [2:0] status, [9:3] char_out
   output logic                                 rsp_tuser,   // [0] has_char
   output logic                                 rsp_tlast    // last
);
   import bsrm_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] TWO_C   = CW'(2);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EXEC = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_ROT  = 7'b0001000,
      S_PSTR = 7'b0010000,
      S_NL   = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [WORD_W-1:0]  value_ff, value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      step_ff, step_in;
   logic               printing_ff, printing_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               out_free;
   logic               emit;
   chain_op_type       chain_op;
   logic [WORD_W-1:0]  ld_word;
   logic               div_start;
   logic               div_done;
   logic [WORD_W-1:0]  div_rem;
   logic               top_is_char;

   logic [WORD_W-1:0]  word [STACK_DEPTH];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   // pstr stops on zero or anything above 127
   assign top_is_char = (word[0][WORD_W-1:CHAR_W] == '0) && (word[0][CHAR_W-1:0] != '0);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      step_in     = step_ff;
      printing_in = printing_ff;
      status_in   = status_ff;
      emit        = 1'b0;
      rsp_in      = '{status: ST_OK, has_char: 1'b0, char_out: '0, last: 1'b1};
      chain_op    = CHAIN_HOLD;
      div_start   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = mode_type'(req_tuser);
               value_in = req_tdata;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               case (mode_ff)
                  MODE_PUSH: begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (count_ff == DEPTH_C) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        chain_op = CHAIN_PUSH;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_MOD: begin
                     if (count_ff < TWO_C) begin
                        emit          = 1'b1;
                        rsp_in.status = ST_SHORT;
                        state_in      = S_IDLE;
                     end else if (word[0] == '0) begin
                        emit          = 1'b1;
                        rsp_in.status = ST_DIVZ;
                        state_in      = S_IDLE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  MODE_PCHAR: begin
                     emit = 1'b1;
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        state_in      = S_IDLE;
                     end else if (word[0][WORD_W-1:CHAR_W] != '0) begin
                        rsp_in.status = ST_NASCII;
                        state_in      = S_IDLE;
                     end else begin
                        rsp_in.has_char = 1'b1;
                        rsp_in.char_out = word[0][CHAR_W-1:0];
                        rsp_in.last     = 1'b0;
                        state_in        = S_NL;
                     end
                  end
                  MODE_PSTR: begin
                     if (count_ff == '0) begin
                        state_in = S_NL;
                     end else begin
                        step_in     = count_ff;
                        printing_in = 1'b1;
                        state_in    = S_PSTR;
                     end
                  end
                  MODE_ROTL: begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (count_ff >= TWO_C) begin
                        chain_op = CHAIN_ROT;
                     end
                  end
                  MODE_ROTR: begin
                     // bottom to top = count-1 top-to-bottom moves
                     if (count_ff >= TWO_C) begin
                        step_in  = count_ff - 1'b1;
                        state_in = S_ROT;
                     end else begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_DIV: begin
            if (div_done) begin
               chain_op  = CHAIN_POP;
               count_in  = count_ff - 1'b1;
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end

         S_ROT: begin
            chain_op = CHAIN_ROT;
            step_in  = step_ff - 1'b1;
            if (step_ff == CW'(1)) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end

         S_PSTR: begin
            // every live word passes slot 0 once, so the stack comes back unchanged
            if (out_free) begin
               if (printing_ff && top_is_char) begin
                  emit            = 1'b1;
                  rsp_in.has_char = 1'b1;
                  rsp_in.char_out = word[0][CHAR_W-1:0];
                  rsp_in.last     = 1'b0;
               end else begin
                  printing_in = 1'b0;
               end
               chain_op = CHAIN_ROT;
               step_in  = step_ff - 1'b1;
               if (step_ff == CW'(1)) begin
                  state_in = S_NL;
               end
            end
         end

         S_NL: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_in.has_char = 1'b1;
               rsp_in.char_out = NEWLINE_CHAR;
               state_in        = S_IDLE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_in.status = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // slot 0 load source: pushed word, remainder, or itself when it wraps to the bottom
   always_comb begin
      case (chain_op)
         CHAIN_PUSH: ld_word = value_ff;
         CHAIN_POP:  ld_word = div_rem;
         CHAIN_ROT:  ld_word = word[0];
         default:    ld_word = word[0];
      endcase
   end

   // ---------------- cell chain ----------------
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] POS = CW'(i + 1);
      cell_op_type        op;
      logic [WORD_W-1:0]  up_w;
      logic [WORD_W-1:0]  down_w;
      logic [WORD_W-1:0]  load_w;

      if (i == 0) begin : g_first
         assign up_w   = '0;
         assign load_w = ld_word;
      end else begin : g_rest
         assign up_w   = word[i-1];
         assign load_w = word[0];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign down_w = '0;
      end else begin : g_inner
         assign down_w = word[i+1];
      end

      always_comb begin
         case (chain_op)
            CHAIN_PUSH: begin
               if (i == 0) op = CELL_LOAD;
               else        op = CELL_UP;
            end
            CHAIN_POP: begin
               if (i == 0) op = CELL_LOAD;
               else        op = CELL_DOWN;
            end
            CHAIN_ROT: begin
               if (POS < count_ff)       op = CELL_DOWN;
               else if (POS == count_ff) op = CELL_LOAD;
               else                      op = CELL_HOLD;
            end
            default:    op = CELL_HOLD;
         endcase
      end

      bsrm_cell u_cell (
         .clock     (clock),
         .op        (op),
         .from_up   (up_w),
         .from_down (down_w),
         .load_word (load_w),
         .word      (word[i])
      );
   end

   // ---------------- remainder unit ----------------
   bsrm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (word[1]),
      .divisor   (word[0]),
      .done      (div_done),
      .remainder (div_rem)
   );

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         printing_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         printing_ff  <= printing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff   <= mode_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - CHAR_W - STATUS_W){1'b0}},
                        rsp_ff.char_out, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.has_char;
   assign rsp_tlast  = rsp_ff.last;

endmodule
`default_nettype wire

@@ design/bsrm_checker.sv @@
`default_nettype none
module bsrm_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire [bsrm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire                               rsp_tuser,
   input  wire                               rsp_tlast
);
   import bsrm_pkg::*;

   // one command at a time: no second accept right behind the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // characters only come with ok status
   a_char_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[STATUS_W-1:0] == ST_OK)
      else $error("character with error status");

   // status-only responses are final and carry no character
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tlast && rsp_tdata[STATUS_W+CHAR_W-1:STATUS_W] == '0)
      else $error("status response not final or has char bits");

endmodule

bind bounded_stack_rotate_mod_engine bsrm_checker u_bsrm_checker (.*);
`default_nettype wire

@@ bench/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsrm_pkg::*;

   localparam int STACK_DEPTH = 32;
   localparam int RESET_CYCLES = 9;
   // long enough for the longest command, a walk of the full chain, to finish
   localparam int TAIL_CYCLES = 40;
   // worst case: every command a full pstr, every response behind a long stall
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_CMDS = 345;

   // stimulus phases: grow the stack, shrink it with mods, or a plain mix
   typedef enum int {
      PH_FILL,
      PH_DRAIN,
      PH_MIXED
   } phase_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] value;
   } stack_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   wire                    req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [31:0] value
   logic [MODE_W-1:0]      req_tuser = '0;   // [2:0] mode

   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire [RSP_TDATA_W-1:0]  rsp_tdata;        // [2:0] status, [9:3] char_out
   wire                    rsp_tuser;        // [0] has_char
   wire                    rsp_tlast;        // last

   bounded_stack_rotate_mod_engine #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // commands waiting to be driven, and responses the shadow stack says must come
   stack_cmd_type pending_cmds[$];
   rsp_type       awaited_rsp[$];

   // shadow of the stack, updated as each request transaction is accepted
   logic [WORD_W-1:0] shadow_words[STACK_DEPTH];
   int                shadow_count = 0;

   int fail_count = 0;
   int cycle_count = 0;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic void await_rsp(status_type st, logic has, logic [CHAR_W-1:0] ch,
                                     logic fin);
      rsp_type r;
      r.status   = st;
      r.has_char = has;
      r.char_out = ch;
      r.last     = fin;
      awaited_rsp.push_back(r);
   endfunction

   // truncated remainder worked on magnitudes; the sign follows the dividend,
   // which also makes the most negative word mod -1 come out as zero
   function automatic logic [WORD_W-1:0] signed_remainder(logic [WORD_W-1:0] dividend,
                                                          logic [WORD_W-1:0] divisor);
      logic [WORD_W-1:0] mag_a;
      logic [WORD_W-1:0] mag_b;
      logic [WORD_W-1:0] rem;
      mag_a = dividend[WORD_W-1] ? -dividend : dividend;
      mag_b = divisor[WORD_W-1] ? -divisor : divisor;
      rem   = mag_a % mag_b;
      return dividend[WORD_W-1] ? -rem : rem;
   endfunction

   function automatic void apply_command(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] value);
      logic [WORD_W-1:0] w;
      int i;
      case (mode)
         MODE_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               await_rsp(ST_FULL, 1'b0, '0, 1'b1);
            end else begin
               shadow_words[shadow_count] = value;
               shadow_count++;
               await_rsp(ST_OK, 1'b0, '0, 1'b1);
            end
         end
         MODE_MOD: begin
            // short stack is checked ahead of the zero divisor
            if (shadow_count < 2) begin
               await_rsp(ST_SHORT, 1'b0, '0, 1'b1);
            end else if (shadow_words[shadow_count-1] == '0) begin
               await_rsp(ST_DIVZ, 1'b0, '0, 1'b1);
            end else begin
               shadow_words[shadow_count-2] = signed_remainder(shadow_words[shadow_count-2],
                                                               shadow_words[shadow_count-1]);
               shadow_count--;
               await_rsp(ST_OK, 1'b0, '0, 1'b1);
            end
         end
         MODE_PCHAR: begin
            if (shadow_count == 0) begin
               await_rsp(ST_EMPTY, 1'b0, '0, 1'b1);
            end else begin
               w = shadow_words[shadow_count-1];
               if (w > 127) begin
                  await_rsp(ST_NASCII, 1'b0, '0, 1'b1);
               end else begin
                  await_rsp(ST_OK, 1'b1, w[CHAR_W-1:0], 1'b0);
                  await_rsp(ST_OK, 1'b1, NEWLINE_CHAR, 1'b1);
               end
            end
         end
         MODE_PSTR: begin
            // walk down from the top; stop on zero, non-ascii or the bottom
            i = shadow_count;
            while (i > 0 && shadow_words[i-1] != '0 && shadow_words[i-1] <= 127) begin
               w = shadow_words[i-1];
               await_rsp(ST_OK, 1'b1, w[CHAR_W-1:0], 1'b0);
               i--;
            end
            await_rsp(ST_OK, 1'b1, NEWLINE_CHAR, 1'b1);
         end
         MODE_ROTL: begin
            if (shadow_count >= 2) begin
               w = shadow_words[shadow_count-1];
               for (i = shadow_count - 1; i > 0; i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[0] = w;
            end
            await_rsp(ST_OK, 1'b0, '0, 1'b1);
         end
         MODE_ROTR: begin
            if (shadow_count >= 2) begin
               w = shadow_words[0];
               for (i = 0; i < shadow_count - 1; i++)
                  shadow_words[i] = shadow_words[i+1];
               shadow_words[shadow_count-1] = w;
            end
            await_rsp(ST_OK, 1'b0, '0, 1'b1);
         end
         default: begin
            // undefined codes: no effect, one plain response
            await_rsp(ST_OK, 1'b0, '0, 1'b1);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic queue_cmd(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] value);
      stack_cmd_type c;
      c.mode  = mode;
      c.value = value;
      pending_cmds.push_back(c);
   endtask

   // push data: nearly half ascii so pstr gets long runs, plus zeros,
   // small signed values for the remainder signs, extremes and raw noise
   function automatic logic [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return WORD_W'($urandom_range(1, 127));
      if (r < 50) return '0;
      if (r < 65) return WORD_W'($urandom_range(0, 18)) - WORD_W'(9);
      if (r < 75) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd128;
            default: return 32'd1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(phase_type ph);
      int r;
      int w_push;
      int w_mod;
      int w_pchar;
      int w_pstr;
      case (ph)
         PH_FILL: begin
            w_push = 70; w_mod = 4; w_pchar = 6; w_pstr = 8;
         end
         PH_DRAIN: begin
            w_push = 10; w_mod = 55; w_pchar = 8; w_pstr = 7;
         end
         default: begin
            w_push = 35; w_mod = 25; w_pchar = 10; w_pstr = 10;
         end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_push) return MODE_PUSH;
      r -= w_push;
      if (r < w_mod) return MODE_MOD;
      r -= w_mod;
      if (r < w_pchar) return MODE_PCHAR;
      r -= w_pchar;
      if (r < w_pstr) return MODE_PSTR;
      r -= w_pstr;
      // a few undefined codes, the rest split between the rotates
      if (r < 4) return MODE_W'(6 + $urandom_range(0, 1));
      return ($urandom_range(0, 1) != 0) ? MODE_ROTL : MODE_ROTR;
   endfunction

   task automatic build_stimulus();
      phase_type ph;
      int phase_left;
      logic [MODE_W-1:0] m;
      // empty-stack corners
      queue_cmd(MODE_PSTR,  32'd0);         // newline only
      queue_cmd(MODE_PCHAR, 32'd0);         // empty
      queue_cmd(MODE_MOD,   32'd0);         // too short
      queue_cmd(MODE_ROTL,  32'd0);         // no-op
      queue_cmd(MODE_ROTR,  32'hffff_ffff); // no-op, value ignored
      // one-word corners
      queue_cmd(MODE_PUSH,  32'd72);
      queue_cmd(MODE_MOD,   32'd0);         // still too short
      queue_cmd(MODE_ROTL,  32'd0);
      queue_cmd(MODE_ROTR,  32'd0);
      queue_cmd(MODE_PCHAR, 32'd0);         // 'H' then newline
      // zero divisor leaves the stack alone
      queue_cmd(MODE_PUSH,  32'd0);
      queue_cmd(MODE_MOD,   32'd0);
      // most negative word mod -1 -> 0
      queue_cmd(MODE_PUSH,  32'h8000_0000);
      queue_cmd(MODE_PUSH,  32'hffff_ffff);
      queue_cmd(MODE_MOD,   32'd0);
      // -7 mod 2 -> -1, sign follows the dividend
      queue_cmd(MODE_PUSH,  32'hffff_fff9);
      queue_cmd(MODE_PUSH,  32'd2);
      queue_cmd(MODE_MOD,   32'd0);
      queue_cmd(MODE_PCHAR, 32'd0);         // -1 is not ascii
      // pstr stops at a non-ascii word under the top
      queue_cmd(MODE_PUSH,  32'h7fff_ffff);
      queue_cmd(MODE_PUSH,  32'd127);
      queue_cmd(MODE_PSTR,  32'd0);
      queue_cmd(MODE_ROTL,  32'd0);
      queue_cmd(MODE_W'(6), 32'h5555_aaaa);
      queue_cmd(MODE_W'(7), 32'haaaa_5555);

      ph = PH_FILL;
      phase_left = 45;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (phase_left == 0) begin
            ph = phase_type'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 50);
         end
         phase_left--;
         m = pick_mode(ph);
         queue_cmd(m, (m == MODE_PUSH) ? pick_word() : $urandom());
      end
   endtask

   // ------------------------------------------------------------------------
   // Idle lengths: mostly none or short, a few long; quiet stretches have none
   // ------------------------------------------------------------------------

   function automatic int idle_length(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: feeds request transactions from pending_cmds
   // ------------------------------------------------------------------------

   int            send_gap = 0;
   bit            send_quiet = 1'b0;
   stack_cmd_type next_cmd;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // transaction accepted at this edge: advance the shadow stack
         if (req_tvalid && req_tready)
            apply_command(req_tuser, req_tdata);
         // slot is free once the current transaction is taken or none is up
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               req_tvalid <= 1'b0;
               send_gap--;
            end else if (pending_cmds.size() > 0) begin
               next_cmd = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_cmd.value;
               req_tuser  <= next_cmd.mode;
               if ($urandom_range(0, 49) == 0)
                  send_quiet = !send_quiet;
               send_gap = idle_length(send_quiet);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each response transaction against the oldest expectation
   // ------------------------------------------------------------------------

   int      stall_left = 0;
   bit      recv_quiet = 1'b0;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response: expected none,", $time,
                        " got tdata %h tuser %b tlast %b", rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_tdata[2:0] !== want.status || rsp_tdata[9:3] !== want.char_out ||
                   rsp_tuser !== want.has_char || rsp_tlast !== want.last) begin
                  fail_count++;
                  $display("%0t: response mismatch:", $time,
                           " expected status %0d has_char %0b char %0d last %0b,",
                           want.status, want.has_char, want.char_out, want.last,
                           " got status %0d has_char %0b char %0d last %0b",
                           rsp_tdata[2:0], rsp_tuser, rsp_tdata[9:3], rsp_tlast);
               end
            end
         end
         // back-pressure: random stalls, with quiet stretches of none
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 49) == 0)
               recv_quiet = !recv_quiet;
            if ($urandom_range(0, 3) == 0)
               stall_left = idle_length(recv_quiet);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, run the stimulus, drain, report
   // ------------------------------------------------------------------------

   initial begin
      build_stimulus();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // sample away from the active edge so the driver and monitor have settled
      do
         @(negedge clock);
      while (pending_cmds.size() > 0 || req_tvalid || awaited_rsp.size() > 0);
      // anything that shows up now is caught by the monitor as unexpected
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ bounded_stack_rotate_mod_engine.f @@
design/bsrm_pkg.sv
design/bsrm_cell.sv
design/bsrm_divider.sv
design/bounded_stack_rotate_mod_engine.sv
design/bsrm_checker.sv
bench/tb.sv
